@@ hdl/hashed_volume_block_extent_mapper_core_assert.svh @@
// Assertion macros shared by the extent mapper modules.
// Needs nothing else; each module that checks itself includes this header.
`ifndef HASHED_VOLUME_BLOCK_EXTENT_MAPPER_CORE_ASSERT_SVH
`define HASHED_VOLUME_BLOCK_EXTENT_MAPPER_CORE_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define HVBEM_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define HVBEM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/hvbem_pkg.sv @@
// Shared types and constants for the hashed volume block extent mapper.
// Used by every module of the block; depends on nothing.
`default_nettype none

package hvbem_pkg;

    // Configuration register indexes.
    localparam logic [7:0] REG_START_DATA_BLOCK = 8'd0;
    localparam logic [7:0] REG_LAYOUT_MODE      = 8'd1;

    typedef enum logic [1:0] {
        LAYOUT_MULTI    = 2'd0,
        LAYOUT_SINGLE   = 2'd1,
        LAYOUT_ENHANCED = 2'd2,
        LAYOUT_OTHER    = 2'd3
    } layout_mode_t;

    // Volume geometry.
    localparam int          FRAG_BLOCKS   = 'h14388;
    localparam int          L0_BLOCKS     = 'h198;
    localparam logic [27:0] FRAG_BYTES    = 28'hA290000;
    localparam logic [27:0] HEADER_BYTES  = 28'hB000;
    localparam logic [27:0] WRAP_BASE     = 28'h2000;
    localparam logic [32:0] ENHANCED_SKIP = 33'h2;
    localparam logic [19:0] BLOCK_BYTES   = 20'h800;
    localparam logic [19:0] LENGTH_MAX    = 20'd835584;

    // Both divisors are multiples of eight, so the low three bits pass
    // straight through and the rest is divided by the odd factor.
    localparam int FRAG_DIV = FRAG_BLOCKS / 8;
    localparam int L0_DIV   = L0_BLOCKS / 8;

    // Rounded-up reciprocals; the shifts are large enough that the
    // quotient is exact over the whole input range.
    localparam int          Q_SHIFT  = 43;
    localparam logic [29:0] Q_RECIP  =
        30'(((64'd1 << Q_SHIFT) + 64'(FRAG_DIV) - 64'd1) / 64'(FRAG_DIV));
    localparam int          L0_SHIFT = 20;
    localparam logic [14:0] L0_RECIP =
        15'(((64'd1 << L0_SHIFT) + 64'(L0_DIV) - 64'd1) / 64'(L0_DIV));

    localparam int HVBEM_OUTQ_DEPTH = 4;

    // One mapped block.
    typedef struct packed {
        logic [15:0] frag;
        logic [27:0] addr;
        logic        below;
        logic        is_first;
        logic        is_final;
    } hvbem_map_t;

    // One extent result.
    typedef struct packed {
        logic [15:0] frag;
        logic [27:0] addr;
        logic [19:0] length;
        logic        file_done;
        logic        below;
    } hvbem_result_t;

    // Pushes from the run merge into the output queue.
    typedef struct packed {
        logic push0;
        logic push1;
    } hvbem_push_t;

endpackage

`default_nettype wire

@@ hdl/hvbem_map.sv @@
// Block-to-address translation pipeline with the configuration registers.
// Depends on hvbem_pkg.
`default_nettype none

module hvbem_map
    import hvbem_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    input  wire logic        adv,
    input  wire logic        in_valid,
    input  wire logic [31:0] block_number,
    input  wire logic        first_block,
    input  wire logic        final_block,
    output logic             out_valid,
    output hvbem_map_t       out_item
);

    logic [23:0]  start_reg;
    layout_mode_t mode_reg;

    logic        s1_valid_reg;
    logic [31:0] s1_blk_reg;
    logic        s1_first_reg, s1_final_reg;

    logic        s2_valid_reg;
    logic [32:0] s2_tb_reg;
    logic        s2_below_reg, s2_first_reg, s2_final_reg;

    logic        s3_valid_reg;
    logic [15:0] s3_q_reg;
    logic [29:0] s3_t3_reg;
    logic [2:0]  s3_low_reg;
    logic        s3_below_reg, s3_first_reg, s3_final_reg;

    logic        s4_valid_reg;
    logic [15:0] s4_fi_reg;
    logic [16:0] s4_fb_reg;
    logic        s4_below_reg, s4_first_reg, s4_final_reg;

    logic        s5_valid_reg;
    logic [15:0] s5_fi_reg;
    logic [16:0] s5_fb_reg;
    logic [7:0]  s5_l0_reg;
    logic        s5_below_reg, s5_first_reg, s5_final_reg;

    logic        s6_valid_reg;
    hvbem_map_t  s6_item_reg;

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            mode_reg  <= LAYOUT_MULTI;
        end else if (cfg_valid) begin
            if (cfg_index == REG_START_DATA_BLOCK) begin
                start_reg <= cfg_data;
            end else if (cfg_index == REG_LAYOUT_MODE) begin
                mode_reg <= layout_mode_t'(cfg_data[1:0]);
            end
        end
    end

    // Stage 1 comb: remove twice the start block, clamp at zero, add the skip in enhanced mode.
    logic [32:0] blk_ext, twice_start, tb_base, tb_next;
    logic        below_next;
    always_comb begin
        blk_ext     = {1'b0, s1_blk_reg};
        twice_start = {8'b0, start_reg, 1'b0};
        below_next  = blk_ext < twice_start;
        tb_base     = below_next ? 33'd0 : blk_ext - twice_start;
        tb_next     = (mode_reg == LAYOUT_ENHANCED) ? tb_base + ENHANCED_SKIP : tb_base;
    end

    // Stage 2 comb: fragment quotient by reciprocal multiplication.
    logic [29:0] t3;
    logic [59:0] q_prod;
    always_comb begin
        t3     = s2_tb_reg[32:3];
        q_prod = 60'(t3) * 60'(Q_RECIP);
    end

    // Stage 3 comb: remainder gives the block within the fragment.
    logic [29:0] q_times_div, rem;
    always_comb begin
        q_times_div = 30'(s3_q_reg) * 30'(FRAG_DIV);
        rem         = s3_t3_reg - q_times_div;
    end

    // Stage 4 comb: level-0 table count before this block.
    logic [28:0] l0_prod;
    always_comb begin
        l0_prod = 29'(s4_fb_reg[16:3]) * 29'(L0_RECIP);
    end

    // Stage 5 comb: byte address and fragment wrap. The level-1 term is
    // always one, since a fragment holds far fewer level-0 tables than one
    // level-1 table covers.
    logic [27:0] data_off, hash_off, hdr_off, addr_raw, addr_next;
    logic [15:0] fi_next;
    logic [8:0]  tables;
    always_comb begin
        tables   = 9'(s5_l0_reg) + 9'd2;
        data_off = {s5_fb_reg, 11'b0};
        hash_off = {7'b0, tables, 12'b0};
        hdr_off  = (mode_reg == LAYOUT_SINGLE) ? HEADER_BYTES : 28'd0;
        addr_raw = data_off + hash_off + hdr_off;
        if (addr_raw >= FRAG_BYTES) begin
            addr_next = addr_raw - FRAG_BYTES + WRAP_BASE;
            fi_next   = s5_fi_reg + 16'd1;
        end else begin
            addr_next = addr_raw;
            fi_next   = s5_fi_reg;
        end
    end

    // Stage valid bits; the whole pipeline moves together on adv.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_blk_reg   <= block_number;
            s1_first_reg <= first_block;
            s1_final_reg <= final_block;

            s2_tb_reg    <= tb_next;
            s2_below_reg <= below_next;
            s2_first_reg <= s1_first_reg;
            s2_final_reg <= s1_final_reg;

            s3_q_reg     <= q_prod[Q_SHIFT +: 16];
            s3_t3_reg    <= t3;
            s3_low_reg   <= s2_tb_reg[2:0];
            s3_below_reg <= s2_below_reg;
            s3_first_reg <= s2_first_reg;
            s3_final_reg <= s2_final_reg;

            s4_fi_reg    <= s3_q_reg;
            s4_fb_reg    <= {rem[13:0], s3_low_reg};
            s4_below_reg <= s3_below_reg;
            s4_first_reg <= s3_first_reg;
            s4_final_reg <= s3_final_reg;

            s5_fi_reg    <= s4_fi_reg;
            s5_fb_reg    <= s4_fb_reg;
            s5_l0_reg    <= l0_prod[L0_SHIFT +: 8];
            s5_below_reg <= s4_below_reg;
            s5_first_reg <= s4_first_reg;
            s5_final_reg <= s4_final_reg;

            s6_item_reg.frag     <= fi_next;
            s6_item_reg.addr     <= addr_next;
            s6_item_reg.below    <= s5_below_reg;
            s6_item_reg.is_first <= s5_first_reg;
            s6_item_reg.is_final <= s5_final_reg;
        end
    end

    assign out_valid = s6_valid_reg;
    assign out_item  = s6_item_reg;

endmodule

`default_nettype wire

@@ hdl/hvbem_merge.sv @@
// Run merge: joins contiguous blocks into extents and emits closed extents.
// Depends on hvbem_pkg and the assertion macro header.
`default_nettype none

`include "hashed_volume_block_extent_mapper_core_assert.svh"

module hvbem_merge
    import hvbem_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        adv,
    input  wire logic        in_valid,
    input  wire hvbem_map_t  in_item,
    output hvbem_push_t      push,
    output hvbem_result_t    res0,
    output hvbem_result_t    res1
);

    logic        run_open_reg, run_open_next;
    logic [15:0] run_frag_reg, run_frag_next;
    logic [27:0] run_addr_reg, run_addr_next;
    logic [19:0] run_len_reg, run_len_next;
    logic [27:0] prev_addr_reg, prev_addr_next;
    logic        run_below_reg, run_below_next;

    logic        fire, open_eff, contig;
    logic [20:0] len_sum;

    // Next run state and the results this block causes.
    always_comb begin
        fire     = adv && in_valid;
        open_eff = run_open_reg && !in_item.is_first;
        contig   = open_eff && ({1'b0, in_item.addr} == {1'b0, prev_addr_reg} + 29'h800);
        len_sum  = {1'b0, run_len_reg} + {1'b0, BLOCK_BYTES};

        run_frag_next  = run_frag_reg;
        run_addr_next  = run_addr_reg;
        run_len_next   = run_len_reg;
        run_below_next = run_below_reg;
        prev_addr_next = in_item.addr;
        run_open_next  = 1'b1;

        if (contig) begin
            if (len_sum <= {1'b0, LENGTH_MAX}) begin
                run_len_next = len_sum[19:0];
            end
            run_below_next = run_below_reg | in_item.below;
        end else begin
            run_frag_next  = in_item.frag;
            run_addr_next  = in_item.addr;
            run_len_next   = BLOCK_BYTES;
            run_below_next = in_item.below;
        end
        if (in_item.is_final) begin
            run_open_next = 1'b0;
        end

        push.push0 = fire && open_eff && !contig;
        push.push1 = fire && in_item.is_final;

        res0.frag      = run_frag_reg;
        res0.addr      = run_addr_reg;
        res0.length    = run_len_reg;
        res0.file_done = 1'b0;
        res0.below     = run_below_reg;

        res1.frag      = run_frag_next;
        res1.addr      = run_addr_next;
        res1.length    = run_len_next;
        res1.file_done = 1'b1;
        res1.below     = run_below_next;
    end

    // Run state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_open_reg  <= 1'b0;
            run_frag_reg  <= '0;
            run_addr_reg  <= '0;
            run_len_reg   <= '0;
            prev_addr_reg <= '0;
            run_below_reg <= 1'b0;
        end else if (fire) begin
            run_open_reg  <= run_open_next;
            run_frag_reg  <= run_frag_next;
            run_addr_reg  <= run_addr_next;
            run_len_reg   <= run_len_next;
            prev_addr_reg <= prev_addr_next;
            run_below_reg <= run_below_next;
        end
    end

    // An open run always holds a whole number of blocks within the cap.
    `HVBEM_ASSERT_IMPL(a_run_len_range, aclk, aresetn, run_open_reg, (run_len_reg >= BLOCK_BYTES) && (run_len_reg <= LENGTH_MAX) && (run_len_reg[10:0] == 11'd0), "open run has a bad length")
    // The last block of a file always closes the run.
    `HVBEM_ASSERT_NEXT(a_final_closes, aclk, aresetn, fire && in_item.is_final, !run_open_reg, "run left open after final block")
    // Any other block leaves a run open.
    `HVBEM_ASSERT_NEXT(a_block_opens, aclk, aresetn, fire && !in_item.is_final, run_open_reg, "run closed without a final block")

endmodule

`default_nettype wire

@@ hdl/hvbem_outq.sv @@
// Output queue of extent results, taking up to two results per cycle.
// Depends on hvbem_pkg and the assertion macro header.
`default_nettype none

`include "hashed_volume_block_extent_mapper_core_assert.svh"

module hvbem_outq
    import hvbem_pkg::*;
#(
    parameter int DEPTH = HVBEM_OUTQ_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire hvbem_push_t   push,
    input  wire hvbem_result_t res0,
    input  wire hvbem_result_t res1,
    output logic               space2,
    output logic               m_valid,
    input  wire logic          m_ready,
    output hvbem_result_t      m_item
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hvbem_result_t       entry_reg [DEPTH];
    logic [IDX_W-1:0]    wr_ptr_reg, wr_ptr_next, wr_ptr_inc;
    logic [IDX_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                pop;
    hvbem_result_t       wr_first;

    function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] r;
        r = (p == IDX_W'(DEPTH - 1)) ? '0 : p + IDX_W'(1);
        return r;
    endfunction

    // Pointer and occupancy bookkeeping.
    always_comb begin
        pop        = m_valid && m_ready;
        wr_ptr_inc = ptr_inc(wr_ptr_reg);
        wr_first   = push.push0 ? res0 : res1;
        wr_ptr_next = wr_ptr_reg;
        if (push.push0 && push.push1) begin
            wr_ptr_next = ptr_inc(wr_ptr_inc);
        end else if (push.push0 || push.push1) begin
            wr_ptr_next = wr_ptr_inc;
        end
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.push0) + CNT_W'(push.push1) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry writes: the earlier result goes first.
    always_ff @(posedge aclk) begin
        if (push.push0 || push.push1) begin
            entry_reg[wr_ptr_reg] <= wr_first;
        end
        if (push.push0 && push.push1) begin
            entry_reg[wr_ptr_inc] <= res1;
        end
    end

    assign space2  = count_reg <= CNT_W'(DEPTH - 2);
    assign m_valid = count_reg != '0;
    assign m_item  = entry_reg[rd_ptr_reg];

    // Occupancy never passes the depth.
    `HVBEM_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH), "queue count past depth")
    // Results only arrive while two slots are free.
    `HVBEM_ASSERT_IMPL(a_push_room, aclk, aresetn, push.push0 || push.push1, space2, "push into a full queue")
    // An empty queue has its pointers together.
    `HVBEM_ASSERT_IMPL(a_empty_ptrs, aclk, aresetn, count_reg == '0, rd_ptr_reg == wr_ptr_reg, "pointers apart on empty queue")

endmodule

`default_nettype wire

@@ hdl/hashed_volume_block_extent_mapper_core.sv @@
// A block's results pass through the hvbem_map stages and the run merge into the queue.
// Throughput: one block per cycle while the output queue has room for two results.
// A block that closes two extents pushes two results into the output queue, and input
// stalls while the output queue holds more than OUTQ_DEPTH - 2 results.
// Reset (aresetn low, synchronous) clears the configuration, the open run and the queue.
// Top level: instantiates hvbem_map, hvbem_merge and hvbem_outq; uses hvbem_pkg.
`default_nettype none

module hashed_volume_block_extent_mapper_core
    import hvbem_pkg::*;
#(
    parameter int OUTQ_DEPTH = HVBEM_OUTQ_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [23:0] cfg_data,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_block_number,
    input  wire logic        s_first_block,
    input  wire logic        s_final_block,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_fragment_index,
    output logic [27:0]      m_extent_address,
    output logic [19:0]      m_extent_length,
    output logic             m_file_done,
    output logic             m_below_start
);

    logic          adv;
    logic          map_valid;
    hvbem_map_t    map_item;
    hvbem_push_t   push;
    hvbem_result_t res0, res1, head;

    // The pipeline advances whenever the queue can take a worst-case pair.
    assign s_ready   = adv;
    assign cfg_ready = 1'b1;

    hvbem_map u_map (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .adv          (adv),
        .in_valid     (s_valid),
        .block_number (s_block_number),
        .first_block  (s_first_block),
        .final_block  (s_final_block),
        .out_valid    (map_valid),
        .out_item     (map_item)
    );

    hvbem_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (map_valid),
        .in_item  (map_item),
        .push     (push),
        .res0     (res0),
        .res1     (res1)
    );

    hvbem_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .res0    (res0),
        .res1    (res1),
        .space2  (adv),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (head)
    );

    // Result fields.
    assign m_fragment_index = head.frag;
    assign m_extent_address = head.addr;
    assign m_extent_length  = head.length;
    assign m_file_done      = head.file_done;
    assign m_below_start    = head.below;

endmodule

`default_nettype wire
